// ===== rtl/lqs_pkg.sv =====
// ============================================================================
// Linear queue with search: shared types and constants
// Operation and status codes, the result record and the field widths used by
// the controller and the top level.
// ============================================================================
`timescale 1ns / 1ps

package lqs_pkg;

   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int MATCH_W     = 4;
   localparam int CFG_W       = 5;
   localparam int QSIZE_RESET = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int RSP_BITS    = 3 * DATA_W + MATCH_W + 2;
   localparam int TDATA_W     = ((RSP_BITS + 7) / 8) * 8;
   localparam int TDATA_PAD   = TDATA_W - RSP_BITS;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQ    = 2'd0,
      FUNC_DEQ    = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  removed_value;
      logic [MATCH_W-1:0]        match_index;
      logic signed [DATA_W-1:0]  head_value;
      logic signed [DATA_W-1:0]  tail_value;
      logic                      is_full;
      logic                      is_empty;
      logic                      last;
   } rsp_type;

endpackage

// ===== rtl/lqs_mem.sv =====
// ============================================================================
// Linear queue with search: slot memory
// Single-port-write, single-port-read synchronous memory with a registered
// read that holds its data while no read is enabled.
// ============================================================================
`timescale 1ns / 1ps

module lqs_mem
   import lqs_pkg::*;
#(
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lqs_ctrl.sv =====
// ============================================================================
// Linear queue with search: controller
// Keeps the head and write positions, runs enqueue, dequeue and the search
// scan against the slot memory, and holds the result register.
// ============================================================================
`timescale 1ns / 1ps

module lqs_ctrl
   import lqs_pkg::*;
#(
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int POS_W  = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [POS_W-1:0]         eff_size,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  func_type                 req_func,
   input  logic signed [DATA_W-1:0] req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp,
   output logic                     mem_wr_en,
   output logic [ADDR_W-1:0]        mem_wr_addr,
   output logic signed [DATA_W-1:0] mem_wr_data,
   output logic                     mem_rd_en,
   output logic [ADDR_W-1:0]        mem_rd_addr,
   input  logic signed [DATA_W-1:0] mem_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic [POS_W-1:0]         rp_ff, rp_in;
   logic [POS_W-1:0]         wp_ff, wp_in;
   logic signed [DATA_W-1:0] head_ff, head_in;
   logic signed [DATA_W-1:0] tail_ff, tail_in;
   logic signed [DATA_W-1:0] rem_ff, rem_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]         scan_ff, scan_in;
   logic                     cmp_v_ff, cmp_v_in;
   logic [POS_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     pend_v_ff, pend_v_in;
   logic [POS_W-1:0]         pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_v_ff, rsp_v_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     out_free;
   logic                     q_empty;
   logic                     q_full;
   logic                     accept;
   logic                     hit;
   logic                     stall;
   logic [POS_W-1:0]         rp_next;
   logic [POS_W-1:0]         wp_next;

   function automatic rsp_type make_rsp(
      status_type               st,
      logic signed [DATA_W-1:0] rem,
      logic [POS_W-1:0]         idx,
      logic                     lst,
      logic signed [DATA_W-1:0] hd,
      logic signed [DATA_W-1:0] tl,
      logic [POS_W-1:0]         rp,
      logic [POS_W-1:0]         wp,
      logic [POS_W-1:0]         eff
   );
      rsp_type                  r;
      logic [POS_W+MATCH_W-1:0] ext;
      logic                     emp;
      emp             = (rp >= wp);
      ext             = {{MATCH_W{1'b0}}, idx};
      r.status        = st;
      r.removed_value = rem;
      r.match_index   = ext[MATCH_W-1:0];
      r.head_value    = emp ? '0 : hd;
      r.tail_value    = emp ? '0 : tl;
      r.is_full       = (wp >= eff);
      r.is_empty      = emp;
      r.last          = lst;
      return r;
   endfunction

   assign out_free  = !rsp_v_ff || rsp_ready;
   assign q_empty   = (rp_ff >= wp_ff);
   assign q_full    = (wp_ff >= eff_size);
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign hit       = cmp_v_ff && (mem_rd_data == key_ff);
   assign stall     = hit && pend_v_ff && !out_free;
   assign rp_next   = rp_ff + POS_W'(1);
   assign wp_next   = wp_ff + POS_W'(1);

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      rem_in      = rem_ff;
      key_in      = key_ff;
      scan_in     = scan_ff;
      cmp_v_in    = cmp_v_ff;
      cmp_idx_in  = cmp_idx_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      cnt_in      = cnt_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wp_ff[ADDR_W-1:0];
      mem_wr_data = req_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ENQ: begin
                     rsp_v_in = 1'b1;
                     if (q_full) begin
                        rsp_in = make_rsp(ST_OVERFLOW, '0, '0, 1'b1, head_ff, tail_ff,
                                          rp_ff, wp_ff, eff_size);
                     end else begin
                        mem_wr_en = 1'b1;
                        wp_in     = wp_next;
                        tail_in   = req_data;
                        head_in   = q_empty ? req_data : head_ff;
                        rsp_in    = make_rsp(ST_OK, '0, '0, 1'b1, head_in, req_data,
                                             rp_ff, wp_next, eff_size);
                     end
                  end
                  FUNC_DEQ: begin
                     if (q_empty) begin
                        rsp_v_in = 1'b1;
                        rsp_in   = make_rsp(ST_EMPTY, '0, '0, 1'b1, head_ff, tail_ff,
                                            rp_ff, wp_ff, eff_size);
                     end else begin
                        rp_in       = rp_next;
                        rem_in      = head_ff;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = rp_next[ADDR_W-1:0];
                        state_in    = S_DEQ;
                     end
                  end
                  FUNC_SEARCH: begin
                     if (q_empty) begin
                        rsp_v_in = 1'b1;
                        rsp_in   = make_rsp(ST_EMPTY, '0, '0, 1'b1, head_ff, tail_ff,
                                            rp_ff, wp_ff, eff_size);
                     end else begin
                        key_in    = req_data;
                        scan_in   = rp_ff;
                        cmp_v_in  = 1'b0;
                        pend_v_in = 1'b0;
                        cnt_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_v_in = 1'b1;
                     rsp_in   = make_rsp(ST_OK, '0, '0, 1'b1, head_ff, tail_ff,
                                         rp_ff, wp_ff, eff_size);
                  end
               endcase
            end
         end
         S_DEQ: begin
            head_in  = mem_rd_data;
            rsp_v_in = 1'b1;
            rsp_in   = make_rsp(ST_OK, rem_ff, '0, 1'b1, mem_rd_data, tail_ff,
                                rp_ff, wp_ff, eff_size);
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     rsp_v_in = 1'b1;
                     rsp_in   = make_rsp(ST_OK, '0, pend_idx_ff, 1'b0, head_ff, tail_ff,
                                         rp_ff, wp_ff, eff_size);
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = cmp_idx_ff;
                  cnt_in      = cnt_ff + CNT_W'(1);
               end
               if (hit && (cnt_ff == CNT_W'(MAX_RESULTS - 1))) begin
                  cmp_v_in = 1'b0;
                  state_in = S_FIN;
               end else if (scan_ff < wp_ff) begin
                  mem_rd_en  = 1'b1;
                  cmp_v_in   = 1'b1;
                  cmp_idx_in = scan_ff;
                  scan_in    = scan_ff + POS_W'(1);
               end else begin
                  cmp_v_in = 1'b0;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               if (pend_v_ff) begin
                  rsp_in = make_rsp(ST_OK, '0, pend_idx_ff, 1'b1, head_ff, tail_ff,
                                    rp_ff, wp_ff, eff_size);
               end else begin
                  rsp_in = make_rsp(ST_NOT_FOUND, '0, '0, 1'b1, head_ff, tail_ff,
                                    rp_ff, wp_ff, eff_size);
               end
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rp_ff     <= '0;
         wp_ff     <= '0;
         cmp_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         cnt_ff    <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         cmp_v_ff  <= cmp_v_in;
         pend_v_ff <= pend_v_in;
         cnt_ff    <= cnt_in;
         rsp_v_ff  <= rsp_v_in;
      end
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      rem_ff      <= rem_in;
      key_ff      <= key_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   a_rp_within_wp: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= wp_ff)
      else $error("Head position passed the write position.");

   a_wp_within_depth: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= POS_W'(DEPTH))
      else $error("Write position ran past the slot memory.");

   a_match_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("Search reported more matches than allowed.");

   a_enq_tail: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_ENQ && !q_full) |=> tail_ff == $past(req_data))
      else $error("Tail does not hold the value just enqueued.");

endmodule

// ===== rtl/linear_queue_with_search.sv =====
// ============================================================================
// Linear queue with search
// Top level: stream ports, the queue size register and the slot memory.
// ============================================================================
`timescale 1ns / 1ps

// Enqueue, dequeue and search on a non-wrapping array queue of signed 32-bit
// values held in a synchronous slot memory. One transaction is worked on at a
// time. Enqueue and the no-operation code are answered from idle, dequeue
// fetches the new head from the memory, and search scans the live slots,
// one slot per cycle through the single memory read port unless a stall on
// the result side pauses it. A search produces one result per match, lowest
// slot first, up to MAX_RESULTS, or one not-found result, with tlast on the
// final one. The next request is taken only when the output register is
// empty or its result leaves in the same cycle. The queue size register may
// be written only while the block is idle; values above DEPTH act as DEPTH.

module linear_queue_with_search
   import lqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,   // queue_size
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,     // data_in
   input  logic [FUNC_W-1:0]    req_tuser,     // func
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,     // removed_value, match_index,
                                               // head_value, tail_value,
                                               // is_full, is_empty, zero pad
   output logic [STATUS_W-1:0]  rsp_tuser,     // status
   output logic                 rsp_tlast
);

   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W     = $clog2(DEPTH + 1);
   localparam int EFF_RESET = (QSIZE_RESET > DEPTH) ? DEPTH : QSIZE_RESET;

   logic [POS_W-1:0]         eff_size_ff, eff_size_in;
   rsp_type                  rsp;
   logic                     mem_wr_en;
   logic [ADDR_W-1:0]        mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [ADDR_W-1:0]        mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;

   always_comb begin
      eff_size_in = eff_size_ff;
      if (csr_wr_en) begin
         if (int'(csr_wr_data) > DEPTH) begin
            eff_size_in = POS_W'(DEPTH);
         end else begin
            eff_size_in = POS_W'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_size_ff <= POS_W'(EFF_RESET);
      end else begin
         eff_size_ff <= eff_size_in;
      end
   end

   lqs_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lqs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .eff_size    (eff_size_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (func_type'(req_tuser)),
      .req_data    (signed'(req_tdata)),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   assign rsp_tdata = {{TDATA_PAD{1'b0}}, rsp.is_empty, rsp.is_full, rsp.tail_value,
                       rsp.head_value, rsp.match_index, rsp.removed_value};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
